[sv/nem_pkg.sv]
// Shared types, constants and codes of the nearest embedding match unit.
`default_nettype none

package nem_pkg;

  localparam int NUM_ENTRIES_DEF = 64;
  localparam int DIMS_DEF        = 512;

  localparam int ENTRY_W   = 6;
  localparam int DIM_IN_W  = 9;
  localparam int VALUE_W   = 16;
  localparam int DIST_W    = 42;
  localparam int COUNT_W   = 7;
  localparam int SQ_W      = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIST_W-1:0] DIST_MAX     = '1;
  localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(1) << 30;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_SQ = 1'b0,
    REG_ENTRY_COUNT  = 1'b1
  } nem_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } nem_state_t;

  typedef struct packed {
    logic                      op;
    logic [ENTRY_W-1:0]        entry;
    logic [DIM_IN_W-1:0]       dim;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } nem_in_t;

  typedef struct packed {
    logic               known;
    logic [ENTRY_W-1:0] winner;
    logic [DIST_W-1:0]  distance_sq;
  } nem_out_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [ENTRY_W-1:0] entry;
  } nem_issue_t;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] winner;
    logic [DIST_W-1:0]  min_dist;
  } nem_best_t;

endpackage

`default_nettype wire

[sv/nearest_embedding_match_unit.sv]
// Top level of the nearest embedding match unit: configuration registers and block wiring.
// Load items and query items that are not last are accepted back to back while the unit is idle.
// A last query item starts a search over min(entry_count, NUM_ENTRIES) entries of DIMS elements,
// one element read per cycle from the reference memory port; the distance pipeline then drains
// and the result register is loaded.
// Reset returns the control state and the configuration registers to their reset values; the memories are not cleared.
`default_nettype none

module nearest_embedding_match_unit #(
  parameter int NUM_ENTRIES = nem_pkg::NUM_ENTRIES_DEF,
  parameter int DIMS        = nem_pkg::DIMS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire nem_pkg::nem_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output nem_pkg::nem_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [nem_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nem_pkg::DIST_W-1:0]        cfg_data
);
  import nem_pkg::*;

  localparam int DIM_AW    = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int REF_DEPTH = NUM_ENTRIES * DIMS;
  localparam int REF_AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;

  logic [DIST_W-1:0]         threshold_sq;
  logic [COUNT_W-1:0]        entry_count;
  nem_issue_t                issue;
  logic [DIM_AW-1:0]         rd_q_addr;
  logic [REF_AW-1:0]         rd_r_addr;
  logic signed [VALUE_W-1:0] q_data;
  logic signed [VALUE_W-1:0] r_data;
  logic                      clear;
  nem_best_t                 best;
  logic                      dist_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sq <= THRESH_RESET;
      entry_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD_SQ: threshold_sq <= cfg_data;
        REG_ENTRY_COUNT:  entry_count  <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  nem_store #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .DIMS        (DIMS),
    .DIM_AW      (DIM_AW),
    .REF_AW      (REF_AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_valid && in_ready),
    .wr_item   (in_data),
    .rd_en     (issue.valid),
    .rd_q_addr (rd_q_addr),
    .rd_r_addr (rd_r_addr),
    .q_data    (q_data),
    .r_data    (r_data)
  );

  nem_dist #(
    .DIM_AW (DIM_AW)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .issue  (issue),
    .q_data (q_data),
    .r_data (r_data),
    .best   (best),
    .idle   (dist_idle)
  );

  nem_seq #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .DIMS        (DIMS),
    .DIM_AW      (DIM_AW),
    .REF_AW      (REF_AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_data),
    .threshold_sq (threshold_sq),
    .entry_count  (entry_count),
    .issue        (issue),
    .rd_q_addr    (rd_q_addr),
    .rd_r_addr    (rd_r_addr),
    .clear        (clear),
    .best         (best),
    .dist_idle    (dist_idle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

[sv/nem_store.sv]
// Query and reference element memories with one write port and one registered read port each.
`default_nettype none

module nem_store #(
  parameter int NUM_ENTRIES = nem_pkg::NUM_ENTRIES_DEF,
  parameter int DIMS        = nem_pkg::DIMS_DEF,
  parameter int DIM_AW      = 9,
  parameter int REF_AW      = 15
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire nem_pkg::nem_in_t                  wr_item,
  input  wire logic                              rd_en,
  input  wire logic [DIM_AW-1:0]                 rd_q_addr,
  input  wire logic [REF_AW-1:0]                 rd_r_addr,
  output logic signed [nem_pkg::VALUE_W-1:0]     q_data,
  output logic signed [nem_pkg::VALUE_W-1:0]     r_data
);
  import nem_pkg::*;

  localparam int REF_DEPTH = NUM_ENTRIES * DIMS;

  logic signed [VALUE_W-1:0] qmem [DIMS];
  logic signed [VALUE_W-1:0] rmem [REF_DEPTH];

  logic              dim_ok;
  logic              entry_ok;
  logic              q_we;
  logic              r_we;
  logic [DIM_AW-1:0] q_wr_addr;
  logic [REF_AW-1:0] r_wr_addr;

  assign dim_ok    = 32'(wr_item.dim) < 32'(DIMS);
  assign entry_ok  = 32'(wr_item.entry) < 32'(NUM_ENTRIES);
  assign q_we      = wr_en && dim_ok && (wr_item.op == OP_QUERY);
  assign r_we      = wr_en && dim_ok && entry_ok && (wr_item.op == OP_LOAD);
  assign q_wr_addr = DIM_AW'(wr_item.dim);
  assign r_wr_addr = REF_AW'(32'(wr_item.entry) * 32'(DIMS) + 32'(wr_item.dim));

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_wr_addr] <= wr_item.value;
    end
    if (rd_en) begin
      q_data <= qmem[rd_q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_wr_addr] <= wr_item.value;
    end
    if (rd_en) begin
      r_data <= rmem[rd_r_addr];
    end
  end

endmodule

`default_nettype wire

[sv/nem_dist.sv]
// Distance pipeline: difference, square, per-entry accumulation and running minimum.
`default_nettype none

module nem_dist #(
  parameter int DIM_AW = 9
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                clear,
  input  wire nem_pkg::nem_issue_t                 issue,
  input  wire logic signed [nem_pkg::VALUE_W-1:0]  q_data,
  input  wire logic signed [nem_pkg::VALUE_W-1:0]  r_data,
  output nem_pkg::nem_best_t                       best,
  output logic                                     idle
);
  import nem_pkg::*;

  localparam int ACC_W = (SQ_W + DIM_AW > DIST_W) ? SQ_W + DIM_AW : DIST_W;

  nem_issue_t                  s1;
  nem_issue_t                  s2;
  nem_issue_t                  s3;
  nem_issue_t                  s4;
  logic signed [VALUE_W:0]     diff;
  logic signed [2*VALUE_W+1:0] prod;
  logic [SQ_W-1:0]             sq;
  logic [ACC_W-1:0]            acc;
  logic [DIST_W-1:0]           dist_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else begin
      s1 <= issue;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
    end
  end

  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    diff <= {q_data[VALUE_W-1], q_data} - {r_data[VALUE_W-1], r_data};
    sq   <= prod[SQ_W-1:0];
    if (s3.valid) begin
      acc <= s3.first ? ACC_W'(sq) : acc + ACC_W'(sq);
    end
  end

  assign dist_sat = (acc > ACC_W'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found    <= 1'b0;
      best.winner   <= '0;
      best.min_dist <= DIST_MAX;
    end else if (s4.valid && s4.last && (!best.found || dist_sat < best.min_dist)) begin
      best.found    <= 1'b1;
      best.winner   <= s4.entry;
      best.min_dist <= dist_sat;
    end
  end

  assign idle = !(s1.valid || s2.valid || s3.valid || s4.valid);

  a_busy_after_issue: assert property (@(posedge clk) disable iff (rst)
    issue.valid |=> !idle)
    else $error("Pipeline reports idle right after an element read was issued.");

  a_found_after_entry: assert property (@(posedge clk) disable iff (rst)
    (s4.valid && s4.last && !clear) |=> best.found)
    else $error("No best entry recorded after a finished distance.");

endmodule

`default_nettype wire

[sv/nem_seq.sv]
// Search sequencer: item intake, read address walk over entries and dims, result register.
`default_nettype none

module nem_seq #(
  parameter int NUM_ENTRIES = nem_pkg::NUM_ENTRIES_DEF,
  parameter int DIMS        = nem_pkg::DIMS_DEF,
  parameter int DIM_AW      = 9,
  parameter int REF_AW      = 15
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire nem_pkg::nem_in_t                in_item,
  input  wire logic [nem_pkg::DIST_W-1:0]      threshold_sq,
  input  wire logic [nem_pkg::COUNT_W-1:0]     entry_count,
  output nem_pkg::nem_issue_t                  issue,
  output logic [DIM_AW-1:0]                    rd_q_addr,
  output logic [REF_AW-1:0]                    rd_r_addr,
  output logic                                 clear,
  input  wire nem_pkg::nem_best_t              best,
  input  wire logic                            dist_idle,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output nem_pkg::nem_out_t                    out_data
);
  import nem_pkg::*;

  localparam int ENT_W = $clog2(NUM_ENTRIES + 1);

  nem_state_t        state;
  nem_state_t        state_next;
  logic [DIM_AW-1:0] d;
  logic [ENT_W-1:0]  j;
  logic [REF_AW-1:0] addr;
  logic [ENT_W-1:0]  active;
  logic              start;
  logic              dim_end;
  logic              ent_end;
  logic              load_out;
  logic              issue_valid;

  assign active  = (32'(entry_count) > 32'(NUM_ENTRIES)) ? ENT_W'(NUM_ENTRIES)
                                                         : ENT_W'(entry_count);
  assign start   = in_valid && in_ready && (in_item.op == OP_QUERY) && in_item.last;
  assign dim_end = 32'(d) == 32'(DIMS - 1);
  assign ent_end = 32'(j) + 32'd1 == 32'(active);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (active == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (dim_end && ent_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dist_idle) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    issue_valid = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_RUN:   issue_valid = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_out = !out_valid || out_ready;
    endcase
  end

  assign issue       = '{valid: issue_valid, first: (d == '0), last: dim_end,
                         entry: ENTRY_W'(j)};
  assign clear       = start;
  assign rd_q_addr   = d;
  assign rd_r_addr   = addr;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      d    <= '0;
      j    <= '0;
      addr <= '0;
    end else if (state == ST_RUN) begin
      if (dim_end) begin
        d <= '0;
        j <= j + ENT_W'(1);
      end else begin
        d <= d + DIM_AW'(1);
      end
      addr <= addr + REF_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.known       <= best.found && (best.min_dist < threshold_sq);
      out_data.winner      <= best.winner;
      out_data.distance_sq <= best.min_dist;
    end
  end

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> dist_idle)
    else $error("Result taken while distance pipeline still holds elements.");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (32'(j) < 32'(active)))
    else $error("Entry walk ran past the active entry count.");

endmodule

`default_nettype wire

[dv/nem_match_checker.sv]
// Checker for the nearest embedding match unit: predicts each search result and compares it.
module nem_match_checker import nem_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int DIMS        = DIMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  nem_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  nem_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [DIST_W-1:0]         threshold_sq_q;
  logic [COUNT_W-1:0]        entry_count_q;
  logic signed [VALUE_W-1:0] query_vec [DIMS];
  logic signed [VALUE_W-1:0] ref_store [NUM_ENTRIES][DIMS];
  nem_out_t                  match_q [$];

  function automatic nem_out_t nearest_match();
    nem_out_t res;
    int unsigned active;
    longint unsigned acc;
    int diff;
    res.known = 1'b0;
    res.winner = '0;
    res.distance_sq = DIST_MAX;
    active = (entry_count_q > NUM_ENTRIES) ? NUM_ENTRIES : entry_count_q;
    for (int e = 0; e < active; e++) begin
      acc = 0;
      for (int d = 0; d < DIMS; d++) begin
        diff = int'(query_vec[d]) - int'(ref_store[e][d]);
        acc += longint'(diff) * longint'(diff);
      end
      if (acc > DIST_MAX) acc = DIST_MAX;
      if (e == 0 || acc < res.distance_sq) begin
        res.winner = ENTRY_W'(e);
        res.distance_sq = acc[DIST_W-1:0];
      end
    end
    res.known = (active != 0) && (res.distance_sq < threshold_sq_q);
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    nem_out_t want;
    if (rst) begin
      threshold_sq_q = THRESH_RESET;
      entry_count_q = '0;
      match_q.delete();
    end else begin
      if (cfg_we) begin
        case (nem_reg_t'(cfg_index))
          REG_THRESHOLD_SQ: threshold_sq_q = cfg_data;
          REG_ENTRY_COUNT:  entry_count_q = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = match_q.pop_front();
          if (out_data.known !== want.known) begin
            $error("known: expected %0d, actual %0d", want.known, out_data.known);
            fail_count++;
          end
          if (out_data.winner !== want.winner) begin
            $error("winner: expected %0d, actual %0d", want.winner, out_data.winner);
            fail_count++;
          end
          if (out_data.distance_sq !== want.distance_sq) begin
            $error("distance_sq: expected %0d, actual %0d",
                   want.distance_sq, out_data.distance_sq);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_LOAD) begin
          if (in_data.entry < NUM_ENTRIES && in_data.dim < DIMS)
            ref_store[in_data.entry][in_data.dim] = in_data.value;
        end else begin
          if (in_data.dim < DIMS) query_vec[in_data.dim] = in_data.value;
          if (in_data.last) match_q = {match_q, nearest_match()};
        end
      end
    end
    pending <= match_q.size();
  end

endmodule

[dv/tb_nearest_embedding_match_unit.sv]
// Testbench top for the nearest embedding match unit: stimulus, clock, reset and verdict.
module tb_nearest_embedding_match_unit;
  import nem_pkg::*;

  localparam int CYCLE_LIMIT   = 10000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1950;
  localparam logic [DIST_W-1:0] EDGE_DIST = 42'd4294836225;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  nem_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  nem_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIST_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int in_idle_pct;
  int out_stall_pct;
  int rand_items;
  logic signed [VALUE_W-1:0] base_vec [DIMS_DEF];

  nearest_embedding_match_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nem_match_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return VALUE_W'(int'($urandom_range(0, 15)) - 8);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] rand_threshold();
    logic [DIST_W-1:0] raw;
    raw = DIST_W'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DIST_MAX;
      2:       return THRESH_RESET;
      default: return raw >> $urandom_range(0, DIST_W - 1);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [ENTRY_W-1:0] entry,
                           input logic [DIM_IN_W-1:0] dim,
                           input logic signed [VALUE_W-1:0] value, input logic last);
    nem_in_t item;
    item.op = op;
    item.entry = entry;
    item.dim = dim;
    item.value = value;
    item.last = last;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [DIST_W-1:0] thr, input int unsigned count);
    cfg_we <= 1'b1;
    cfg_index <= REG_THRESHOLD_SQ;
    cfg_data <= thr;
    @(posedge clk);
    cfg_index <= REG_ENTRY_COUNT;
    cfg_data <= DIST_W'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic search_with(input logic [DIST_W-1:0] thr, input int unsigned count,
                             input int unsigned dim, input logic signed [VALUE_W-1:0] value);
    wait_idle();
    set_config(thr, count);
    send_item(OP_QUERY, ENTRY_W'($urandom_range(63)), DIM_IN_W'(dim), value, 1'b1);
  endtask

  // A random mix of load and query items; a few sequences end without a last query element.
  task automatic run_sequence(input int unsigned active);
    int unsigned len;
    int unsigned hi;
    logic op;
    logic [ENTRY_W-1:0] entry;
    hi = (active == 0 || active > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF - 1 : active - 1;
    len = $urandom_range(0, 16);
    for (int i = 0; i < len; i++) begin
      op = 1'($urandom_range(1));
      entry = ($urandom_range(3) == 0) ? ENTRY_W'($urandom_range(63))
                                       : ENTRY_W'($urandom_range(hi));
      send_item(op, entry, DIM_IN_W'($urandom_range(DIMS_DEF - 1)), rand_value(),
                (op == OP_LOAD) ? 1'($urandom_range(1)) : 1'b0);
    end
    rand_items += len;
    if ($urandom_range(9) != 0) begin
      send_item(OP_QUERY, ENTRY_W'($urandom_range(63)),
                DIM_IN_W'($urandom_range(DIMS_DEF - 1)), rand_value(), 1'b1);
      rand_items++;
    end
  endtask

  initial begin
    int seg;
    int unsigned active;
    int seg_end;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD_SQ;
    cfg_data = '0;
    in_idle_pct = 8;
    out_stall_pct = 71;
    rand_items = 0;
    for (int d = 0; d < DIMS_DEF; d++) base_vec[d] = rand_value();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // An entry count of zero gives no match even with the widest threshold.
    search_with(DIST_MAX, 0, 0, 16'sh0000);

    // Entries 0, 1 and the last slot start equal to the query; the rest are random.
    for (int e = 0; e < NUM_ENTRIES_DEF; e++) begin
      for (int d = 0; d < DIMS_DEF; d++) begin
        send_item(OP_LOAD, ENTRY_W'(e), DIM_IN_W'(d),
                  (e == 0 || e == 1 || e == NUM_ENTRIES_DEF - 1) ? base_vec[d] : rand_value(),
                  1'($urandom_range(1)));
      end
    end
    for (int d = 0; d < DIMS_DEF; d++)
      send_item(OP_QUERY, ENTRY_W'($urandom_range(63)), DIM_IN_W'(d), base_vec[d], 1'b0);

    search_with(THRESH_RESET, 1, 0, base_vec[0]);
    search_with('0, 1, 0, base_vec[0]);
    send_item(OP_LOAD, ENTRY_W'(0), DIM_IN_W'(0), 16'sh8000, 1'b1);
    search_with(THRESH_RESET, 1, 0, 16'sh7fff);
    search_with(EDGE_DIST, 1, 0, 16'sh7fff);
    search_with(EDGE_DIST + 1, 1, 0, 16'sh7fff);
    search_with(THRESH_RESET, 2, 0, base_vec[0]);
    send_item(OP_LOAD, ENTRY_W'(0), DIM_IN_W'(0), base_vec[0], 1'b0);
    search_with(THRESH_RESET, 2, 0, base_vec[0]);
    send_item(OP_LOAD, ENTRY_W'(0), DIM_IN_W'(1), base_vec[1] ^ 16'sh4000, 1'b0);
    send_item(OP_LOAD, ENTRY_W'(1), DIM_IN_W'(2), ~base_vec[2], 1'b0);
    search_with(DIST_MAX, NUM_ENTRIES_DEF, 0, base_vec[0]);
    search_with(THRESH_RESET, 127, DIMS_DEF - 1, base_vec[DIMS_DEF - 1]);

    seg = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end else if (rand_items >= RANDOM_ITEMS / 3) begin
        in_idle_pct = 71;
        out_stall_pct = 8;
      end
      wait_idle();
      if (seg % 6 == 5) begin
        active = (seg % 12 == 5) ? NUM_ENTRIES_DEF : 127;
        set_config(rand_threshold(), active);
        run_sequence(active);
      end else begin
        active = $urandom_range(0, 6);
        set_config(rand_threshold(), active);
        seg_end = rand_items + 80;
        while (rand_items < seg_end) run_sequence(active);
      end
      seg++;
    end

    wait_idle();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
